// File: design/sscu_pkg.sv
package sscu_pkg;

  // Work classes decided by the front end.
  typedef enum logic [2:0] {
    OP_DECLINE,
    OP_FIRST,
    OP_TEMP,
    OP_PASS,
    OP_WSPD,
    OP_WDIR,
    OP_CYC
  } op_e;

  // Subpage numbers in page order.
  localparam logic [7:0] SP_TEMP     = 8'd1;
  localparam logic [7:0] SP_PRESSURE = 8'd2;
  localparam logic [7:0] SP_HUMIDITY = 8'd3;
  localparam logic [7:0] SP_WSPD     = 8'd4;
  localparam logic [7:0] SP_WDIR     = 8'd5;
  localparam logic [7:0] SP_CYCLES   = 8'd6;
  localparam logic [7:0] SP_TMIN     = 8'd7;
  localparam logic [7:0] SP_TMAX     = 8'd8;

  // Field codes of the result.
  localparam logic [2:0] FC_TEMP     = 3'd0;
  localparam logic [2:0] FC_PRESSURE = 3'd1;
  localparam logic [2:0] FC_HUMIDITY = 3'd2;
  localparam logic [2:0] FC_WSPD     = 3'd3;
  localparam logic [2:0] FC_WDIR     = 3'd4;
  localparam logic [2:0] FC_CYCLES   = 3'd5;
  localparam logic [2:0] FC_TMIN     = 3'd6;
  localparam logic [2:0] FC_TMAX     = 3'd7;

  // Quantity kinds of the result.
  localparam logic [2:0] QK_TEMPERATURE = 3'd0;
  localparam logic [2:0] QK_PRESSURE    = 3'd1;
  localparam logic [2:0] QK_HUMIDITY    = 3'd2;
  localparam logic [2:0] QK_SPEED       = 3'd3;
  localparam logic [2:0] QK_ANGLE       = 3'd4;
  localparam logic [2:0] QK_COUNT       = 3'd5;

  // Decimal exponents.
  localparam logic signed [3:0] EXP_CENTI = -4'sd2;
  localparam logic signed [3:0] EXP_DECA  = 4'sd1;
  localparam logic signed [3:0] EXP_MICRO = -4'sd6;
  localparam logic signed [3:0] EXP_UNIT  = 4'sd0;

  // Kelvin offset in hundredths.
  localparam logic [63:0] KELVIN_CENTI = 64'd27315;

  // Wind speed: (v*1e6+180)/360 = 2777*v + floor((14*v+9)/18).
  // The division by 18 is a reciprocal multiply, exact for a 20-bit numerator.
  localparam logic [27:0] WSPD_INT      = 28'd2777;
  localparam logic [19:0] WSPD_FRAC_MUL = 20'd14;
  localparam logic [19:0] WSPD_FRAC_ADD = 20'd9;
  localparam logic [20:0] WSPD_RECIP    = 21'd1864136;

  // Wind direction: floor((v*872665+500000)/1e6) = floor(floor(x/64)/15625).
  // The division by 15625 is a reciprocal multiply, exact for a 30-bit value.
  localparam logic [35:0] WDIR_MUL   = 36'd872665;
  localparam logic [35:0] WDIR_BIAS  = 36'd500000;
  localparam logic [30:0] WDIR_RECIP = 31'd1125899907;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    op_e               op;
    logic [2:0]        field_code;
    logic [2:0]        quantity_kind;
    logic signed [3:0] exponent;
    logic [15:0]       operand;
    logic [31:0]       source_id;
    logic [63:0]       time_us;
    logic [31:0]       declined_total;
  } sscu_item_t;

  // One finished result.
  typedef struct packed {
    logic              posted;
    logic [2:0]        field_code;
    logic [2:0]        quantity_kind;
    logic signed [3:0] exponent;
    logic signed [63:0] value;
    logic              accumulating;
    logic [31:0]       source_out;
    logic [63:0]       time_out;
    logic [31:0]       declined_total;
  } sscu_res_t;

endpackage

// File: design/sscu_if.sv
// Input request channel.
interface sscu_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  subpage;
  logic [15:0] wire_value;
  logic [31:0] source_id;
  logic [63:0] time_us;

  modport source(output valid, subpage, wire_value, source_id, time_us, input ready);
  modport sink(input valid, subpage, wire_value, source_id, time_us, output ready);
endinterface

// Result channel.
interface sscu_res_if;
  logic               valid;
  logic               ready;
  logic               posted;
  logic [2:0]         field_code;
  logic [2:0]         quantity_kind;
  logic signed [3:0]  exponent;
  logic signed [63:0] value;
  logic               accumulating;
  logic [31:0]        source_out;
  logic [63:0]        time_out;
  logic [31:0]        declined_total;

  modport source(output valid, posted, field_code, quantity_kind, exponent, value,
                 accumulating, source_out, time_out, declined_total, input ready);
  modport sink(input valid, posted, field_code, quantity_kind, exponent, value,
               accumulating, source_out, time_out, declined_total, output ready);
endinterface

// File: design/sscu_front.sv
module sscu_front
  import sscu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sscu_req_if.sink   req_i,
  output sscu_item_t item_o,
  output logic       item_valid_o,
  input  logic       item_ready_i
);

  logic        seen_q, seen_d;
  logic [15:0] prev_q, prev_d;
  logic [31:0] decl_q, decl_d;
  logic        fire;

  assign req_i.ready  = item_ready_i;
  assign item_valid_o = req_i.valid;
  assign fire         = req_i.valid && item_ready_i;

  // Classify the request and update the in-order state on acceptance.
  always_comb begin
    item_o                = '0;
    item_o.op             = OP_DECLINE;
    item_o.declined_total = decl_q;
    seen_d                = seen_q;
    prev_d                = prev_q;
    decl_d                = decl_q;
    unique case (req_i.subpage)
      SP_TEMP, SP_TMIN, SP_TMAX: begin
        item_o.op            = OP_TEMP;
        item_o.quantity_kind = QK_TEMPERATURE;
        item_o.exponent      = EXP_CENTI;
        item_o.operand       = req_i.wire_value;
        if (req_i.subpage == SP_TMIN) begin
          item_o.field_code = FC_TMIN;
        end else if (req_i.subpage == SP_TMAX) begin
          item_o.field_code = FC_TMAX;
        end else begin
          item_o.field_code = FC_TEMP;
        end
      end
      SP_PRESSURE: begin
        item_o.op            = OP_PASS;
        item_o.field_code    = FC_PRESSURE;
        item_o.quantity_kind = QK_PRESSURE;
        item_o.exponent      = EXP_DECA;
        item_o.operand       = req_i.wire_value;
      end
      SP_HUMIDITY: begin
        item_o.op            = OP_PASS;
        item_o.field_code    = FC_HUMIDITY;
        item_o.quantity_kind = QK_HUMIDITY;
        item_o.exponent      = EXP_CENTI;
        item_o.operand       = req_i.wire_value;
      end
      SP_WSPD: begin
        item_o.op            = OP_WSPD;
        item_o.field_code    = FC_WSPD;
        item_o.quantity_kind = QK_SPEED;
        item_o.exponent      = EXP_MICRO;
        item_o.operand       = req_i.wire_value;
      end
      SP_WDIR: begin
        item_o.op            = OP_WDIR;
        item_o.field_code    = FC_WDIR;
        item_o.quantity_kind = QK_ANGLE;
        item_o.exponent      = EXP_MICRO;
        item_o.operand       = req_i.wire_value;
      end
      SP_CYCLES: begin
        seen_d = fire ? 1'b1 : seen_q;
        prev_d = fire ? req_i.wire_value : prev_q;
        if (seen_q) begin
          // The operand carries the 16-bit wrapped delta.
          item_o.op            = OP_CYC;
          item_o.field_code    = FC_CYCLES;
          item_o.quantity_kind = QK_COUNT;
          item_o.exponent      = EXP_UNIT;
          item_o.operand       = req_i.wire_value - prev_q;
        end else begin
          item_o.op = OP_FIRST;
        end
      end
      default: begin
        item_o.declined_total = decl_q + 32'd1;
        decl_d                = fire ? decl_q + 32'd1 : decl_q;
      end
    endcase
    // Only posted samples carry the sender and the timestamp.
    if (item_o.op != OP_DECLINE && item_o.op != OP_FIRST) begin
      item_o.source_id = req_i.source_id;
      item_o.time_us   = req_i.time_us;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      prev_q <= '0;
      decl_q <= '0;
    end else begin
      seen_q <= seen_d;
      prev_q <= prev_d;
      decl_q <= decl_d;
    end
  end

endmodule

// File: design/sscu_queue.sv
module sscu_queue
  import sscu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sscu_item_t push_item_i,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  output sscu_item_t pop_item_o,
  output logic       pop_valid_o,
  input  logic       pop_ready_i
);

  sscu_item_t  mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: design/sscu_back.sv
module sscu_back
  import sscu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sscu_item_t item_i,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  sscu_res_if.source res_o
);

  // Stage A: first products.
  logic        a_v_q;
  sscu_item_t  a_item_q;
  logic [40:0] a_spd_frac_q;
  logic [27:0] a_spd_int_q;
  logic [35:0] a_dir_x_q;
  // Stage B: speed sum and direction reciprocal product.
  logic        b_v_q;
  sscu_item_t  b_item_q;
  logic [27:0] b_speed_q;
  logic [60:0] b_dir_prod_q;
  // Stage C: output register and accumulator.
  logic        c_v_q;
  sscu_res_t   c_res_q, c_res_d;
  logic [63:0] acc_q, acc_d;

  logic        a_rdy, b_rdy, c_rdy;
  logic        a_load, b_load, c_load;
  logic [19:0] spd_num;

  // Stall chain from the output back to the queue.
  assign c_rdy        = !c_v_q || res_o.ready;
  assign b_rdy        = !b_v_q || c_rdy;
  assign a_rdy        = !a_v_q || b_rdy;
  assign item_ready_o = a_rdy;
  assign a_load       = item_valid_i && a_rdy;
  assign b_load       = a_v_q && b_rdy;
  assign c_load       = b_v_q && c_rdy;

  assign spd_num = {4'd0, item_i.operand} * WSPD_FRAC_MUL + WSPD_FRAC_ADD;

  // Final value selection and accumulator update.
  always_comb begin
    acc_d   = acc_q + {48'd0, b_item_q.operand};
    c_res_d = '0;
    c_res_d.declined_total = b_item_q.declined_total;
    unique case (b_item_q.op)
      OP_TEMP:  c_res_d.value = {{48{b_item_q.operand[15]}}, b_item_q.operand} + KELVIN_CENTI;
      OP_PASS:  c_res_d.value = {48'd0, b_item_q.operand};
      OP_WSPD:  c_res_d.value = {36'd0, b_speed_q};
      OP_WDIR:  c_res_d.value = {47'd0, b_dir_prod_q[60:44]};
      OP_CYC:   c_res_d.value = acc_d;
      default:  c_res_d.value = '0;
    endcase
    if (b_item_q.op != OP_DECLINE && b_item_q.op != OP_FIRST) begin
      c_res_d.posted        = 1'b1;
      c_res_d.field_code    = b_item_q.field_code;
      c_res_d.quantity_kind = b_item_q.quantity_kind;
      c_res_d.exponent      = b_item_q.exponent;
      c_res_d.accumulating  = (b_item_q.op == OP_CYC);
      c_res_d.source_out    = b_item_q.source_id;
      c_res_d.time_out      = b_item_q.time_us;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      acc_q <= '0;
    end else begin
      if (a_rdy) begin
        a_v_q <= item_valid_i;
      end
      if (b_rdy) begin
        b_v_q <= a_v_q;
      end
      if (c_rdy) begin
        c_v_q <= b_v_q;
      end
      if (c_load && b_item_q.op == OP_CYC) begin
        acc_q <= acc_d;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_item_q     <= item_i;
      a_spd_frac_q <= {21'd0, spd_num} * {20'd0, WSPD_RECIP};
      a_spd_int_q  <= {12'd0, item_i.operand} * WSPD_INT;
      a_dir_x_q    <= {20'd0, item_i.operand} * WDIR_MUL + WDIR_BIAS;
    end
    if (b_load) begin
      b_item_q     <= a_item_q;
      b_speed_q    <= a_spd_int_q + {12'd0, a_spd_frac_q[40:25]};
      b_dir_prod_q <= {31'd0, a_dir_x_q[35:6]} * {30'd0, WDIR_RECIP};
    end
    if (c_load) begin
      c_res_q <= c_res_d;
    end
  end

  // Result channel.
  assign res_o.valid          = c_v_q;
  assign res_o.posted         = c_res_q.posted;
  assign res_o.field_code     = c_res_q.field_code;
  assign res_o.quantity_kind  = c_res_q.quantity_kind;
  assign res_o.exponent       = c_res_q.exponent;
  assign res_o.value          = c_res_q.value;
  assign res_o.accumulating   = c_res_q.accumulating;
  assign res_o.source_out     = c_res_q.source_out;
  assign res_o.time_out       = c_res_q.time_out;
  assign res_o.declined_total = c_res_q.declined_total;

endmodule

// File: design/sensor_subfield_unit_converter.sv
// Throughput: one request per cycle while the result channel is ready, set by the three-stage
// reciprocal multiply pipeline in the back end; a two-entry queue decouples it from the
// classifying front end. Reset (asynchronous, active low) clears the charge cycle tracking,
// the accumulator, the decline counter and all valid flags; no clearing pass is needed.
module sensor_subfield_unit_converter
  import sscu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sscu_req_if.sink   req_i,
  sscu_res_if.source res_o
);

  sscu_item_t f_item, q_item;
  logic       f_valid, f_ready;
  logic       q_valid, q_ready;

  sscu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready)
  );

  sscu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (f_item),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_item_o   (q_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  sscu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .res_o        (res_o)
  );

  // A full queue is never empty, so back pressure only comes with queued work.
  a_ready_low_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> q_valid)
    else $error("request side stalled with an empty queue");

  // An unposted result carries nothing but the decline count.
  a_unposted_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.posted |-> res_o.value == 64'd0 && !res_o.accumulating
      && res_o.source_out == 32'd0 && res_o.time_out == 64'd0)
    else $error("unposted result carries sample data");

  // Accumulated results are always charge cycle samples at unit exponent.
  a_accum_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.accumulating |-> res_o.posted
      && res_o.field_code == FC_CYCLES && res_o.exponent == EXP_UNIT)
    else $error("accumulating flag on a non-cycle result");

endmodule
